### rtl/wrp_pkg.sv
// ----------------------------------------------------------------------------
// wrp_pkg
// Types and constants shared by the RIFF/WAVE header parser modules.
// ----------------------------------------------------------------------------
`default_nettype none

package wrp_pkg;

	typedef struct packed {
		logic [7:0] file_byte;
		logic       end_of_file;
	} wav_item_t;

	typedef struct packed {
		logic        is_payload;
		logic [7:0]  payload_byte;
		logic        payload_last;
		logic [3:0]  status;
		logic [15:0] channel_count;
		logic [15:0] sample_bits;
		logic [31:0] sample_rate;
	} pcm_item_t;

	typedef struct packed {
		logic      valid;
		pcm_item_t item;
	} step_res_t;

	localparam int FMT_BYTES = 16;
	typedef logic [FMT_BYTES-1:0][7:0] fmt_bytes_t;

	localparam logic [3:0] ST_OK        = 4'd0;
	localparam logic [3:0] ST_RIFF      = 4'd1;
	localparam logic [3:0] ST_SMALL     = 4'd2;
	localparam logic [3:0] ST_WAVE      = 4'd3;
	localparam logic [3:0] ST_NOFMT     = 4'd4;
	localparam logic [3:0] ST_TAG       = 4'd5;
	localparam logic [3:0] ST_CHANS     = 4'd6;
	localparam logic [3:0] ST_BITS      = 4'd7;
	localparam logic [3:0] ST_RATE      = 4'd8;
	localparam logic [3:0] ST_ALIGN     = 4'd9;
	localparam logic [3:0] ST_BYTERATE  = 4'd10;
	localparam logic [3:0] ST_NODATA    = 4'd11;
	localparam logic [3:0] ST_TRUNCATED = 4'd12;

	localparam int PH_W = 3;
	localparam logic [PH_W-1:0] PH_PRE   = 3'd0;
	localparam logic [PH_W-1:0] PH_HDR   = 3'd1;
	localparam logic [PH_W-1:0] PH_FMT   = 3'd2;
	localparam logic [PH_W-1:0] PH_SKIP  = 3'd3;
	localparam logic [PH_W-1:0] PH_PAD   = 3'd4;
	localparam logic [PH_W-1:0] PH_DATA  = 3'd5;
	localparam logic [PH_W-1:0] PH_DONE  = 3'd6;
	localparam logic [PH_W-1:0] PH_FAULT = 3'd7;

	localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
	localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
	localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
	localparam logic [31:0] TAG_DATA = 32'h6174_6164;

	localparam int RIFF_TAG_LAST = 3;
	localparam int WAVE_TAG_LAST = 11;
	localparam int RIFF_TAG_LEN  = 4;
	localparam int HDR_BYTES     = 8;
	localparam int HDR_ID_BYTES  = 4;

endpackage

`default_nettype wire

### rtl/wrp_fmt_check.sv
// ----------------------------------------------------------------------------
// wrp_fmt_check
// Validates captured fmt chunk fields and returns the first failing status.
// ----------------------------------------------------------------------------
`default_nettype none

module wrp_fmt_check (
	input  wire wrp_pkg::fmt_bytes_t fields,
	output logic [3:0]               code
);

	logic [15:0] fmt_tag;
	logic [15:0] chans;
	logic [31:0] rate;
	logic [31:0] byte_rate;
	logic [15:0] align;
	logic [15:0] bits;
	logic [2:0]  bps;
	logic [3:0]  frame;
	logic [35:0] prod;
	logic        bits_ok;

	assign fmt_tag   = {fields[1], fields[0]};
	assign chans     = {fields[3], fields[2]};
	assign rate      = {fields[7], fields[6], fields[5], fields[4]};
	assign byte_rate = {fields[11], fields[10], fields[9], fields[8]};
	assign align     = {fields[13], fields[12]};
	assign bits      = {fields[15], fields[14]};

	assign bits_ok = (bits == 16'd8) || (bits == 16'd16) || (bits == 16'd24) ||
		(bits == 16'd32);
	assign bps   = bits[5:3];
	assign frame = chans[1] ? {bps, 1'b0} : {1'b0, bps};
	assign prod  = 36'(rate) * 36'(frame);

	always_comb begin
		if (fmt_tag != 16'd1) begin
			code = wrp_pkg::ST_TAG;
		end else if (chans != 16'd1 && chans != 16'd2) begin
			code = wrp_pkg::ST_CHANS;
		end else if (!bits_ok) begin
			code = wrp_pkg::ST_BITS;
		end else if (rate == 32'd0) begin
			code = wrp_pkg::ST_RATE;
		end else if (align != {12'd0, frame}) begin
			code = wrp_pkg::ST_ALIGN;
		end else if (byte_rate != prod[31:0]) begin
			code = wrp_pkg::ST_BYTERATE;
		end else begin
			code = wrp_pkg::ST_OK;
		end
	end

endmodule

`default_nettype wire

### rtl/wrp_parser.sv
// ----------------------------------------------------------------------------
// wrp_parser
// Parse state and per-byte decode: tags, chunk walk, fmt capture, payload.
// ----------------------------------------------------------------------------
`default_nettype none

module wrp_parser #(
	parameter int MIN_FILE_BYTES = 45
) (
	input  wire                      clk,
	input  wire                      arst_n,
	input  wire                      en,
	input  wire wrp_pkg::wav_item_t  item,
	output wrp_pkg::step_res_t       res
);

	localparam int OFS_W = $clog2(MIN_FILE_BYTES + 12);

	logic [wrp_pkg::PH_W-1:0] phase_q, phase_n;
	logic [OFS_W-1:0]         ofs_q, ofs_n;
	logic [31:0]              tag_q, tag_n;
	logic [31:0]              len_q, len_n;
	logic [31:0]              left_q, left_n;
	logic [31:0]              left_dec;
	wrp_pkg::fmt_bytes_t      fld_q, fld_n;
	logic [4:0]               fidx_q, fidx_n;
	logic                     seen_q, seen_n;
	logic [3:0]               fault_q, fault_n;
	logic [3:0]               chk;
	logic                     fmt_open;

	assign left_dec = left_q - 32'd1;
	assign fmt_open = (phase_q == wrp_pkg::PH_HDR) && (left_dec == 32'd0) &&
		(tag_q == wrp_pkg::TAG_FMT) && !seen_q;

	always_comb begin
		fld_n = fld_q;
		if (fmt_open) begin
			fld_n = '0;
		end else if (phase_q == wrp_pkg::PH_FMT && !fidx_q[4]) begin
			fld_n[fidx_q[3:0]] = item.file_byte;
		end
	end

	wrp_fmt_check u_check (
		.fields (fld_n),
		.code   (chk)
	);

	always_comb begin
		logic       emit;
		logic       pay;
		logic       last;
		logic [3:0] st;
		logic       riff_bad;
		logic       short_file;

		phase_n = phase_q;
		tag_n   = tag_q;
		len_n   = len_q;
		left_n  = left_q;
		fidx_n  = fidx_q;
		seen_n  = seen_q;
		fault_n = fault_q;
		emit    = 1'b0;
		pay     = 1'b0;
		last    = 1'b0;
		st      = wrp_pkg::ST_OK;
		ofs_n   = (ofs_q != '1) ? ofs_q + OFS_W'(1) : ofs_q;

		unique case (phase_q)
			wrp_pkg::PH_PRE: begin
				tag_n = {item.file_byte, tag_q[31:8]};
				if (ofs_q == OFS_W'(wrp_pkg::RIFF_TAG_LAST) && tag_n != wrp_pkg::TAG_RIFF) begin
					fault_n = wrp_pkg::ST_RIFF;
					phase_n = wrp_pkg::PH_FAULT;
				end else if (ofs_q == OFS_W'(wrp_pkg::WAVE_TAG_LAST)) begin
					if (tag_n != wrp_pkg::TAG_WAVE) begin
						fault_n = wrp_pkg::ST_WAVE;
						phase_n = wrp_pkg::PH_FAULT;
					end else begin
						phase_n = wrp_pkg::PH_HDR;
						left_n  = 32'(wrp_pkg::HDR_BYTES);
					end
				end
			end
			wrp_pkg::PH_HDR: begin
				if (left_q > 32'(wrp_pkg::HDR_ID_BYTES)) begin
					tag_n = {item.file_byte, tag_q[31:8]};
				end else begin
					len_n = {item.file_byte, len_q[31:8]};
				end
				left_n = left_dec;
				if (left_dec == 32'd0) begin
					if (tag_q == wrp_pkg::TAG_FMT && !seen_q) begin
						seen_n = 1'b1;
						if (len_n == 32'd0) begin
							fault_n = wrp_pkg::ST_TAG;
							phase_n = wrp_pkg::PH_FAULT;
						end else begin
							phase_n = wrp_pkg::PH_FMT;
							left_n  = len_n;
							fidx_n  = 5'd0;
						end
					end else if (tag_q == wrp_pkg::TAG_DATA) begin
						if (!seen_q) begin
							fault_n = wrp_pkg::ST_NOFMT;
							phase_n = wrp_pkg::PH_FAULT;
						end else if (len_n == 32'd0) begin
							emit    = 1'b1;
							phase_n = wrp_pkg::PH_DONE;
						end else begin
							phase_n = wrp_pkg::PH_DATA;
							left_n  = len_n;
						end
					end else if (len_n == 32'd0) begin
						phase_n = wrp_pkg::PH_HDR;
						left_n  = 32'(wrp_pkg::HDR_BYTES);
					end else begin
						phase_n = wrp_pkg::PH_SKIP;
						left_n  = len_n;
					end
				end
			end
			wrp_pkg::PH_FMT: begin
				if (!fidx_q[4]) begin
					fidx_n = fidx_q + 5'd1;
				end
				left_n = left_dec;
				if ((fidx_q == 5'(wrp_pkg::FMT_BYTES - 1) ||
					(left_dec == 32'd0 && len_q < 32'(wrp_pkg::FMT_BYTES))) &&
					chk != wrp_pkg::ST_OK) begin
					fault_n = chk;
					phase_n = wrp_pkg::PH_FAULT;
				end else if (left_dec == 32'd0) begin
					phase_n = len_q[0] ? wrp_pkg::PH_PAD : wrp_pkg::PH_HDR;
					left_n  = 32'(wrp_pkg::HDR_BYTES);
				end
			end
			wrp_pkg::PH_SKIP: begin
				left_n = left_dec;
				if (left_dec == 32'd0) begin
					phase_n = len_q[0] ? wrp_pkg::PH_PAD : wrp_pkg::PH_HDR;
					left_n  = 32'(wrp_pkg::HDR_BYTES);
				end
			end
			wrp_pkg::PH_PAD: begin
				phase_n = wrp_pkg::PH_HDR;
				left_n  = 32'(wrp_pkg::HDR_BYTES);
			end
			wrp_pkg::PH_DATA: begin
				left_n = left_dec;
				emit   = 1'b1;
				pay    = 1'b1;
				last   = (left_dec == 32'd0);
				if (last) begin
					phase_n = wrp_pkg::PH_DONE;
				end
			end
			default: begin
			end
		endcase

		riff_bad = (fault_n == wrp_pkg::ST_RIFF) ||
			(phase_n == wrp_pkg::PH_PRE && ofs_n < OFS_W'(wrp_pkg::RIFF_TAG_LEN));
		short_file = ofs_n < OFS_W'(MIN_FILE_BYTES);

		if (item.end_of_file) begin
			if (emit) begin
				if (pay) begin
					st = short_file ? wrp_pkg::ST_SMALL :
						(last ? wrp_pkg::ST_OK : wrp_pkg::ST_TRUNCATED);
					last = 1'b1;
				end else if (short_file) begin
					st = wrp_pkg::ST_SMALL;
				end
			end else if (phase_n != wrp_pkg::PH_DONE) begin
				emit = 1'b1;
				if (riff_bad) begin
					st = wrp_pkg::ST_RIFF;
				end else if (short_file) begin
					st = wrp_pkg::ST_SMALL;
				end else if (fault_n != wrp_pkg::ST_OK) begin
					st = fault_n;
				end else if (phase_n == wrp_pkg::PH_PRE) begin
					st = wrp_pkg::ST_WAVE;
				end else if (phase_n == wrp_pkg::PH_FMT && !fidx_n[4]) begin
					st = (chk != wrp_pkg::ST_OK) ? chk : wrp_pkg::ST_NODATA;
				end else begin
					st = seen_n ? wrp_pkg::ST_NODATA : wrp_pkg::ST_NOFMT;
				end
			end
		end

		res.valid              = emit;
		res.item.is_payload    = pay;
		res.item.payload_byte  = pay ? item.file_byte : 8'd0;
		res.item.payload_last  = last;
		res.item.status        = st;
		res.item.channel_count = {fld_n[3], fld_n[2]};
		res.item.sample_bits   = {fld_n[15], fld_n[14]};
		res.item.sample_rate   = {fld_n[7], fld_n[6], fld_n[5], fld_n[4]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= wrp_pkg::PH_PRE;
			ofs_q   <= '0;
			tag_q   <= '0;
			len_q   <= '0;
			left_q  <= '0;
			fld_q   <= '0;
			fidx_q  <= '0;
			seen_q  <= 1'b0;
			fault_q <= wrp_pkg::ST_OK;
		end else if (en) begin
			if (item.end_of_file) begin
				phase_q <= wrp_pkg::PH_PRE;
				ofs_q   <= '0;
				tag_q   <= '0;
				len_q   <= '0;
				left_q  <= '0;
				fld_q   <= '0;
				fidx_q  <= '0;
				seen_q  <= 1'b0;
				fault_q <= wrp_pkg::ST_OK;
			end else begin
				phase_q <= phase_n;
				ofs_q   <= ofs_n;
				tag_q   <= tag_n;
				len_q   <= len_n;
				left_q  <= left_n;
				fld_q   <= fld_n;
				fidx_q  <= fidx_n;
				seen_q  <= seen_n;
				fault_q <= fault_n;
			end
		end
	end

endmodule

`default_nettype wire

### rtl/wav_riff_header_parser.sv
// ----------------------------------------------------------------------------
// wav_riff_header_parser
// Byte-stream RIFF/WAVE parser: checks tags, walks chunks, captures and
// validates the fmt chunk and streams out the data chunk payload.
// ----------------------------------------------------------------------------
// Takes one file byte per cycle, held in an input register, and gives at most
// one result per byte through a result register. The parse state machine
// decodes each byte as it leaves the input register, so the sustained rate
// is one byte per clock whenever the result side is not stalled. A result
// is either a payload byte of the data chunk (the last one carries the final
// status) or a status-only item, given on the end-of-file byte when parsing
// failed or the data chunk was absent, or on the last header byte of an empty
// data chunk. The captured channel count, bits and sample rate ride along in
// every result. All state returns to reset after the end-of-file byte.
`default_nettype none

module wav_riff_header_parser #(
	parameter int MIN_FILE_BYTES = 45
) (
	input  wire                      clk,
	input  wire                      arst_n,
	input  wire                      wav_valid,
	output logic                     wav_stall,
	input  wire wrp_pkg::wav_item_t  wav_item,
	output logic                     pcm_valid,
	input  wire                      pcm_stall,
	output wrp_pkg::pcm_item_t       pcm_item
);

	logic                valid_s1;
	wrp_pkg::wav_item_t  item_s1;
	logic                valid_s2;
	wrp_pkg::pcm_item_t  item_s2;
	logic                out_free;
	logic                adv;
	wrp_pkg::step_res_t  res;

	assign out_free  = !valid_s2 || !pcm_stall;
	assign adv       = valid_s1 && out_free;
	assign wav_stall = valid_s1 && !out_free;
	assign pcm_valid = valid_s2;
	assign pcm_item  = item_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (wav_valid && !wav_stall) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (wav_valid && !wav_stall) begin
			item_s1 <= wav_item;
		end
	end

	wrp_parser #(
		.MIN_FILE_BYTES (MIN_FILE_BYTES)
	) u_parser (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (adv),
		.item   (item_s1),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (out_free) begin
			valid_s2 <= adv && res.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && res.valid) begin
			item_s2 <= res.item;
		end
	end

endmodule

`default_nettype wire
